/* hdl/pftm_pkg.sv */
// Shared types and constants of the pulse frequency meter with trimmed-mean smoothing.
`timescale 1ns / 1ps
package pftm_pkg;

   // Field widths
   localparam int F_W     = 40;   // frequency, signed Q.8 Hz
   localparam int CNT_W   = 24;   // counter, timer and preset width
   localparam int COUNT_W = CNT_W + 2;   // signed pulse count

   // Reading decode
   localparam logic [CNT_W-1:0] PRESET_RESET = CNT_W'(10);
   localparam logic [CNT_W-1:0] TIMER_FULL   = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0] TICK_RATE_HZ = CNT_W'(10000000);
   localparam int Q8_SHIFT = 8;

   // Magnitude product |count| * tick rate
   localparam int PROD_W = (COUNT_W - 1) + CNT_W;

   // Divider: two quotient bits per cycle over an even-width dividend
   localparam int DIVIDEND_W = 2 * ((PROD_W + Q8_SHIFT + 1) / 2);
   localparam int DIV_STEPS  = DIVIDEND_W / 2;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // Smoothing window
   localparam int WINDOW_LENGTH = 8;
   localparam int PTR_W    = $clog2(WINDOW_LENGTH);
   localparam int SUM_W    = F_W + $clog2(WINDOW_LENGTH);
   localparam int TRIM_DIV = WINDOW_LENGTH - 2;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Saturation limits
   localparam logic signed [F_W-1:0] F_MAX = {1'b0, {(F_W-1){1'b1}}};
   localparam logic signed [F_W-1:0] F_MIN = {1'b1, {(F_W-1){1'b0}}};

   // One classified reading
   typedef struct packed {
      logic                      overflow;
      logic signed [COUNT_W-1:0] count;
      logic [CNT_W-1:0]          ticks;
   } job_type;

endpackage

/* hdl/pftm_channels.sv */
// Channel interfaces for readings and results.
`timescale 1ns / 1ps
interface pftm_req_if;
   logic                          valid;
   logic                          ready;
   logic                          counter_expired;
   logic [pftm_pkg::CNT_W-1:0]    counter_remaining;
   logic [pftm_pkg::CNT_W-1:0]    timer_ticks;

   modport source (output valid, counter_expired, counter_remaining, timer_ticks,
                   input ready);
   modport sink (input valid, counter_expired, counter_remaining, timer_ticks,
                 output ready);
endinterface

interface pftm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [pftm_pkg::F_W-1:0] filtered_frequency;
   logic signed [pftm_pkg::F_W-1:0] raw_frequency;
   logic                           timer_overflow;

   modport source (output valid, filtered_frequency, raw_frequency, timer_overflow,
                   input ready);
   modport sink (input valid, filtered_frequency, raw_frequency, timer_overflow,
                 output ready);
endinterface

/* hdl/pulse_frequency_trimmed_mean.sv */
// Top level of the pulse frequency meter with trimmed-mean smoothing.
//
//   channel   direction  handshake                 word
//   req_chan  in         valid/ready               counter_expired, counter_remaining, timer_ticks
//   rsp_chan  out        valid/ready               filtered_frequency, raw_frequency, timer_overflow
//   csr_*     in         write enable, no ready    pulse_preset (24 bit)
//
// In the back end a word passes fetch, multiply, the raw-frequency division, the ring write,
// the 8-entry scan, trim, the trimmed-mean division and output; fetch, multiply, trim and
// output each have a state of their own. Both divisions hold the shared two-bit-per-cycle
// divider from start to done. Zero timer ticks skip the first division.
// Reset is synchronous: preset goes to 10, the ring to zero, and all queues empty.
// The front takes up to three words ahead while the back is busy; a stalled result holds in
// the output register and blocks only the back.
`timescale 1ns / 1ps
module pulse_frequency_trimmed_mean (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [pftm_pkg::CNT_W-1:0]  csr_write_data,
   pftm_req_if.sink                    req_chan,
   pftm_rsp_if.source                  rsp_chan
);

   logic               front_valid;
   pftm_pkg::job_type  front_job;
   logic               front_ready;
   logic               queue_valid;
   pftm_pkg::job_type  queue_job;
   logic               queue_pop;

   // Accept and decode readings
   pftm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_chan),
      .out_valid        (front_valid),
      .out_job          (front_job),
      .out_ready        (front_ready)
   );

   // Buffer decoded words
   pftm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_job   (front_job),
      .push_ready (front_ready),
      .pop_valid  (queue_valid),
      .pop_job    (queue_job),
      .pop        (queue_pop)
   );

   // Compute frequency and smoothed result
   pftm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_valid),
      .job       (queue_job),
      .job_pop   (queue_pop),
      .rsp       (rsp_chan)
   );

endmodule

/* hdl/pftm_front.sv */
// Front end: preset register, reading acceptance and pulse-count decode.
`timescale 1ns / 1ps
module pftm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [pftm_pkg::CNT_W-1:0]  csr_write_data,
   pftm_req_if.sink                    req,
   output logic                        out_valid,
   output pftm_pkg::job_type           out_job,
   input  logic                        out_ready
);

   logic [pftm_pkg::CNT_W-1:0]         preset_ff;
   logic                               hold_valid_ff;
   logic                               hold_valid_in;
   pftm_pkg::job_type                  hold_job_ff;
   pftm_pkg::job_type                  job_in;
   logic signed [pftm_pkg::COUNT_W-1:0] preset_s;
   logic signed [pftm_pkg::COUNT_W-1:0] rem_s;
   logic signed [pftm_pkg::COUNT_W-1:0] one_s;
   logic                               accept;

   // Take a word whenever the holding stage is free or draining
   assign req.ready = !hold_valid_ff || out_ready;
   assign accept    = req.valid && req.ready;

   assign preset_s = $signed(pftm_pkg::COUNT_W'(preset_ff));
   assign rem_s    = $signed(pftm_pkg::COUNT_W'(req.counter_remaining));
   assign one_s    = $signed(pftm_pkg::COUNT_W'(1));

   // Decode pulse count: expired counter wins over a saturated timer
   always_comb begin
      job_in.ticks    = req.timer_ticks;
      job_in.overflow = 1'b0;
      if (req.counter_expired) begin
         job_in.count = preset_s - one_s;
      end else if (req.timer_ticks == pftm_pkg::TIMER_FULL) begin
         job_in.count    = -one_s;
         job_in.overflow = 1'b1;
      end else begin
         job_in.count = preset_s - rem_s - one_s;
      end
   end

   assign hold_valid_in = accept || (hold_valid_ff && !out_ready);

   // Hold preset and the decoded word
   always_ff @(posedge clock) begin
      if (reset) begin
         preset_ff     <= pftm_pkg::PRESET_RESET;
         hold_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            preset_ff <= csr_write_data;
         end
         hold_valid_ff <= hold_valid_in;
      end
      if (accept) begin
         hold_job_ff <= job_in;
      end
   end

   assign out_valid = hold_valid_ff;
   assign out_job   = hold_job_ff;

endmodule

/* hdl/pftm_queue.sv */
// Short queue of decoded words between front and back.
`timescale 1ns / 1ps
module pftm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  pftm_pkg::job_type  push_job,
   output logic               push_ready,
   output logic               pop_valid,
   output pftm_pkg::job_type  pop_job,
   input  logic               pop
);

   pftm_pkg::job_type           entry_ff [pftm_pkg::QUEUE_DEPTH];
   logic [pftm_pkg::QPTR_W-1:0] wr_ff;
   logic [pftm_pkg::QPTR_W-1:0] rd_ff;
   logic [pftm_pkg::QCNT_W-1:0] cnt_ff;
   logic [pftm_pkg::QPTR_W-1:0] wr_in;
   logic [pftm_pkg::QPTR_W-1:0] rd_in;
   logic [pftm_pkg::QCNT_W-1:0] cnt_in;
   logic                        do_push;
   logic                        do_pop;

   assign push_ready = cnt_ff != pftm_pkg::QCNT_W'(pftm_pkg::QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_job    = entry_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == pftm_pkg::QPTR_W'(pftm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == pftm_pkg::QPTR_W'(pftm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

   // Fill level stays within the depth
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= pftm_pkg::QCNT_W'(pftm_pkg::QUEUE_DEPTH))
      else $error("queue fill level beyond depth");

   // A lone push raises the fill level by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue fill level did not follow push");

   // Pointers agree with the fill level when empty
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> wr_ff == rd_ff)
      else $error("queue pointers disagree on empty queue");

endmodule

/* hdl/pftm_divider.sv */
// Unsigned restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps
module pftm_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pftm_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [pftm_pkg::CNT_W-1:0]       divisor,
   output logic                             busy,
   output logic                             done,
   output logic [pftm_pkg::DIVIDEND_W-1:0]  quotient
);

   logic                               busy_ff;
   logic                               done_ff;
   logic [pftm_pkg::DIV_CNT_W-1:0]     step_ff;
   logic [pftm_pkg::CNT_W-1:0]         rem_ff;
   logic [pftm_pkg::CNT_W-1:0]         rem_in;
   logic [pftm_pkg::DIVIDEND_W-1:0]    quo_ff;
   logic [pftm_pkg::DIVIDEND_W-1:0]    quo_in;
   logic [pftm_pkg::CNT_W-1:0]         dsr_ff;
   logic [pftm_pkg::CNT_W:0]           trial;

   // Two shift-and-subtract steps; dividend bits shift out as quotient bits shift in
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      trial  = '0;
      for (int k = 0; k < 2; k++) begin
         trial  = {rem_in, quo_in[pftm_pkg::DIVIDEND_W-1]};
         quo_in = {quo_in[pftm_pkg::DIVIDEND_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in    = pftm_pkg::CNT_W'(trial - {1'b0, dsr_ff});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[pftm_pkg::CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         step_ff <= pftm_pkg::DIV_CNT_W'(pftm_pkg::DIV_STEPS - 1);
         rem_ff  <= '0;
         quo_ff  <= dividend;
         dsr_ff  <= divisor;
      end else if (busy_ff) begin
         step_ff <= step_ff - 1'b1;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hdl/pftm_back.sv */
// Back end: frequency division, ring update, trimmed mean and result register.
`timescale 1ns / 1ps
module pftm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  pftm_pkg::job_type  job,
   output logic               job_pop,
   pftm_rsp_if.source         rsp
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_RAW_GO, ST_RAW_WAIT, ST_RING,
      ST_SCAN, ST_TRIM, ST_MEAN_GO, ST_MEAN_WAIT, ST_OUT
   } state_type;

   state_type                              state_ff, state_in;
   pftm_pkg::job_type                      job_ff, job_in;
   logic [pftm_pkg::PROD_W-1:0]            prod_ff, prod_in;
   logic                                   neg_ff, neg_in;
   logic signed [pftm_pkg::F_W-1:0]        raw_ff, raw_in;
   logic signed [pftm_pkg::F_W-1:0]        ring_ff [pftm_pkg::WINDOW_LENGTH];
   logic                                   ring_we;
   logic [pftm_pkg::PTR_W-1:0]             wp_ff, wp_in;
   logic [pftm_pkg::PTR_W-1:0]             idx_ff, idx_in;
   logic signed [pftm_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic signed [pftm_pkg::F_W-1:0]        hi_ff, hi_in;
   logic signed [pftm_pkg::F_W-1:0]        lo_ff, lo_in;
   logic signed [pftm_pkg::SUM_W-1:0]      trim_ff, trim_in;
   logic signed [pftm_pkg::F_W-1:0]        filt_ff, filt_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [pftm_pkg::F_W-1:0]        rsp_filt_ff, rsp_filt_in;
   logic signed [pftm_pkg::F_W-1:0]        rsp_raw_ff, rsp_raw_in;
   logic                                   rsp_ovf_ff, rsp_ovf_in;

   logic signed [pftm_pkg::COUNT_W-1:0]    count_abs;
   logic [pftm_pkg::COUNT_W-2:0]           count_mag;
   logic signed [pftm_pkg::F_W-1:0]        scan_val;
   logic signed [pftm_pkg::SUM_W-1:0]      trim_abs;
   logic                                   div_start;
   logic [pftm_pkg::DIVIDEND_W-1:0]        div_dividend;
   logic [pftm_pkg::CNT_W-1:0]             div_divisor;
   logic                                   div_busy;
   logic                                   div_done;
   logic [pftm_pkg::DIVIDEND_W-1:0]        div_quotient;

   // Clamp a sign and magnitude to the signed 40-bit range
   function automatic logic signed [pftm_pkg::F_W-1:0] sat40(
      input logic neg, input logic [pftm_pkg::DIVIDEND_W-1:0] mag);
      logic signed [pftm_pkg::F_W-1:0] res;
      if (!neg) begin
         res = (mag > pftm_pkg::DIVIDEND_W'(pftm_pkg::F_MAX)) ? pftm_pkg::F_MAX
                                                             : $signed(mag[pftm_pkg::F_W-1:0]);
      end else begin
         res = (mag > (pftm_pkg::DIVIDEND_W'(1) << (pftm_pkg::F_W - 1))) ? pftm_pkg::F_MIN
                                                             : -$signed(mag[pftm_pkg::F_W-1:0]);
      end
      return res;
   endfunction

   // Magnitude of the pulse count; the most negative count the decode gives still fits one bit narrower
   assign count_abs = job_ff.count[pftm_pkg::COUNT_W-1] ? -job_ff.count : job_ff.count;
   assign count_mag = count_abs[pftm_pkg::COUNT_W-2:0];
   assign scan_val  = ring_ff[idx_ff];
   assign trim_abs  = trim_ff[pftm_pkg::SUM_W-1] ? -trim_ff : trim_ff;

   // Shared divider: raw frequency first, then the trimmed mean
   assign div_start    = (state_ff == ST_RAW_GO) || (state_ff == ST_MEAN_GO);
   assign div_dividend = (state_ff == ST_RAW_GO)
                         ? pftm_pkg::DIVIDEND_W'({prod_ff, {pftm_pkg::Q8_SHIFT{1'b0}}})
                         : pftm_pkg::DIVIDEND_W'($unsigned(trim_abs));
   assign div_divisor  = (state_ff == ST_RAW_GO) ? job_ff.ticks
                                                 : pftm_pkg::CNT_W'(pftm_pkg::TRIM_DIV);

   pftm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sequence one word through multiply, divide, ring scan and mean
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      raw_in       = raw_ff;
      ring_we      = 1'b0;
      wp_in        = wp_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      trim_in      = trim_ff;
      filt_in      = filt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_filt_in  = rsp_filt_ff;
      rsp_raw_in   = rsp_raw_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      job_pop      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = pftm_pkg::PROD_W'(count_mag) * pftm_pkg::PROD_W'(pftm_pkg::TICK_RATE_HZ);
            neg_in  = job_ff.count[pftm_pkg::COUNT_W-1];
            if (job_ff.ticks == '0) begin
               raw_in   = '0;
               state_in = ST_RING;
            end else begin
               state_in = ST_RAW_GO;
            end
         end
         ST_RAW_GO: begin
            state_in = ST_RAW_WAIT;
         end
         ST_RAW_WAIT: begin
            if (div_done) begin
               raw_in   = sat40(neg_ff, div_quotient);
               state_in = ST_RING;
            end
         end
         ST_RING: begin
            ring_we  = 1'b1;
            wp_in    = (wp_ff == pftm_pkg::PTR_W'(pftm_pkg::WINDOW_LENGTH - 1))
                       ? '0 : wp_ff + 1'b1;
            idx_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (idx_ff == '0) begin
               sum_in = pftm_pkg::SUM_W'(scan_val);
               hi_in  = scan_val;
               lo_in  = scan_val;
            end else begin
               sum_in = sum_ff + pftm_pkg::SUM_W'(scan_val);
               hi_in  = (scan_val > hi_ff) ? scan_val : hi_ff;
               lo_in  = (scan_val < lo_ff) ? scan_val : lo_ff;
            end
            if (idx_ff == pftm_pkg::PTR_W'(pftm_pkg::WINDOW_LENGTH - 1)) begin
               state_in = ST_TRIM;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_TRIM: begin
            trim_in  = sum_ff - pftm_pkg::SUM_W'(hi_ff) - pftm_pkg::SUM_W'(lo_ff);
            state_in = ST_MEAN_GO;
         end
         ST_MEAN_GO: begin
            state_in = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_done) begin
               filt_in  = sat40(trim_ff[pftm_pkg::SUM_W-1], div_quotient);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_filt_in  = filt_ff;
               rsp_raw_in   = raw_ff;
               rsp_ovf_in   = job_ff.overflow;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < pftm_pkg::WINDOW_LENGTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ring_we) begin
            ring_ff[wp_ff] <= raw_ff;
         end
      end
      job_ff      <= job_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      raw_ff      <= raw_in;
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      trim_ff     <= trim_in;
      filt_ff     <= filt_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_raw_ff  <= rsp_raw_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.filtered_frequency = rsp_filt_ff;
   assign rsp.raw_frequency      = rsp_raw_ff;
   assign rsp.timer_overflow     = rsp_ovf_ff;

   // Divider is only started when free
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // Ring pointer stays inside the window
   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= pftm_pkg::PTR_W'(pftm_pkg::WINDOW_LENGTH - 1))
      else $error("ring pointer outside window");

   // A new result appears only out of the output state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside output state");

   // Divider results arrive only while the sequencer waits on them
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_RAW_WAIT || state_ff == ST_MEAN_WAIT))
      else $error("divider finished with no one waiting");

endmodule
